// ===== sv/cascaded_steer_speed_pid_top_macros.svh =====
// Assertion macros for the cascaded steer and speed controller.
// Taken in by the top level; expects clk_i and rst_ni in the using module.
`ifndef CASCADED_STEER_SPEED_PID_TOP_MACROS_SVH
`define CASCADED_STEER_SPEED_PID_TOP_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define CSSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define CSSP_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

// ===== sv/cssp_pkg.sv =====
// Shared types, constants and width helpers for the cascaded steer and speed controller.
// No dependencies; used by the sequencer, the datapath and the top level.
package cssp_pkg;

  localparam int FRAC_BITS_DEF = 8;
  localparam int OUT_WIDTH_DEF = 32;

  localparam int IN_W        = 16;
  localparam int GAIN_W      = 16;
  localparam int GAIN_FRAC   = 8;
  localparam int ALPHA_W     = 9;
  localparam int ALPHA_SHIFT = 8;
  localparam int ALPHA_IDX_W = $clog2(ALPHA_W);
  localparam int ERR_W       = 24;
  localparam int RES_W       = 24;
  localparam int MUL_B_W     = ERR_W + 1;
  localparam int PROD_W      = GAIN_W + MUL_B_W;
  localparam int SUM_W       = PROD_W + 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int TDATA_IN_W  = 4 * IN_W;
  localparam int TDATA_OUT_W = 3 * RES_W;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;

  // Opcodes carried in tuser.
  localparam logic OPC_STEER = 1'b0;
  localparam logic OPC_SPEED = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CRUISE_SPEED = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEER_KP     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEER_KD     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_GAIN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_KI     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_KP     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_ALPHA = 3'd6;

  // Register reset values.
  localparam logic [GAIN_W-1:0]  RST_CRUISE_SPEED = 16'd0;
  localparam logic [GAIN_W-1:0]  RST_STEER_KP     = 16'd4352;
  localparam logic [GAIN_W-1:0]  RST_STEER_KD     = 16'd3584;
  localparam logic [GAIN_W-1:0]  RST_GYRO_GAIN    = 16'd51;
  localparam logic [GAIN_W-1:0]  RST_SPEED_KI     = 16'd512;
  localparam logic [GAIN_W-1:0]  RST_SPEED_KP     = 16'd256;
  localparam logic [ALPHA_W-1:0] RST_FILTER_ALPHA = 9'd230;

  // Width of the shared accumulator: room for the rescaled sum, the loop values,
  // the output extraction and the alpha product.
  function automatic int wide_w(input int frac, input int outw);
    int up;
    int w;
    up = (frac > GAIN_FRAC) ? (frac - GAIN_FRAC) : 0;
    w  = SUM_W + up;
    if (outw > w) w = outw;
    if ((RES_W + frac) > w) w = RES_W + frac;
    return w + 12;
  endfunction

  typedef enum logic [3:0] {
    OP_NOP,
    OP_MUL0,
    OP_MUL1,
    OP_MUL2,
    OP_ACC,
    OP_ERR1,
    OP_ERR2,
    OP_DIFF,
    OP_ALPHA,
    OP_FIN
  } op_e;

  typedef struct packed {
    op_e                    op;
    logic                   steer;
    logic                   side;
    logic [ALPHA_IDX_W-1:0] bit_idx;
  } ctrl_t;

  typedef struct packed {
    logic [GAIN_W-1:0]  cruise_speed;
    logic [GAIN_W-1:0]  steer_kp;
    logic [GAIN_W-1:0]  steer_kd;
    logic [GAIN_W-1:0]  gyro_gain;
    logic [GAIN_W-1:0]  speed_ki;
    logic [GAIN_W-1:0]  speed_kp;
    logic [ALPHA_W-1:0] filter_alpha;
  } cfg_t;

endpackage

// ===== sv/cssp_ctrl.sv =====
// Sequencer that steps the shared multiply-accumulate unit through one item.
// Depends on cssp_pkg for the operation codes and the control struct.
module cssp_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            opcode_i,
  input  logic            out_free_i,
  output cssp_pkg::ctrl_t ctrl_o,
  output logic            idle_o,
  output logic            out_load_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ERR1  = 4'd1;
  localparam logic [3:0] S_ERR2  = 4'd2;
  localparam logic [3:0] S_MUL0  = 4'd3;
  localparam logic [3:0] S_MUL1  = 4'd4;
  localparam logic [3:0] S_MUL2  = 4'd5;
  localparam logic [3:0] S_ACC   = 4'd6;
  localparam logic [3:0] S_DIFF  = 4'd7;
  localparam logic [3:0] S_ALPHA = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  localparam logic [cssp_pkg::ALPHA_IDX_W-1:0] ALPHA_LAST =
    cssp_pkg::ALPHA_IDX_W'(cssp_pkg::ALPHA_W - 1);

  logic [3:0] state_q, state_d;
  logic       steer_q, steer_d;
  logic       side_q, side_d;
  logic [cssp_pkg::ALPHA_IDX_W-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    steer_d = steer_q;
    side_d  = side_q;
    cnt_d   = cnt_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          steer_d = (opcode_i == cssp_pkg::OPC_STEER);
          side_d  = 1'b0;
          state_d = (opcode_i == cssp_pkg::OPC_STEER) ? S_MUL0 : S_ERR1;
        end
      end
      S_ERR1: state_d = S_ERR2;
      S_ERR2: state_d = S_MUL0;
      S_MUL0: state_d = S_MUL1;
      S_MUL1: state_d = steer_q ? S_MUL2 : S_ACC;
      S_MUL2: state_d = S_ACC;
      S_ACC:  state_d = S_DIFF;
      S_DIFF: begin
        cnt_d   = '0;
        state_d = S_ALPHA;
      end
      S_ALPHA: begin
        if (cnt_q == ALPHA_LAST) begin
          state_d = S_FIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_FIN: begin
        // The left wheel is done first, then the right wheel runs the same steps.
        if (!steer_q && !side_q) begin
          side_d  = 1'b1;
          state_d = S_ERR1;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      steer_q <= 1'b0;
      side_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      steer_q <= steer_d;
      side_q  <= side_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    ctrl_o.steer   = steer_q;
    ctrl_o.side    = side_q;
    ctrl_o.bit_idx = cnt_q;
    case (state_q)
      S_ERR1:  ctrl_o.op = cssp_pkg::OP_ERR1;
      S_ERR2:  ctrl_o.op = cssp_pkg::OP_ERR2;
      S_MUL0:  ctrl_o.op = cssp_pkg::OP_MUL0;
      S_MUL1:  ctrl_o.op = cssp_pkg::OP_MUL1;
      S_MUL2:  ctrl_o.op = cssp_pkg::OP_MUL2;
      S_ACC:   ctrl_o.op = cssp_pkg::OP_ACC;
      S_DIFF:  ctrl_o.op = cssp_pkg::OP_DIFF;
      S_ALPHA: ctrl_o.op = cssp_pkg::OP_ALPHA;
      S_FIN:   ctrl_o.op = cssp_pkg::OP_FIN;
      default: ctrl_o.op = cssp_pkg::OP_NOP;
    endcase
  end

  assign idle_o     = (state_q == S_IDLE);
  assign out_load_o = (state_q == S_DONE) && out_free_i;

endmodule

// ===== sv/cssp_dp.sv =====
// Datapath: loop state, one 16x25 multiplier and one wide accumulator shared by all steps.
// Depends on cssp_pkg; driven by the control struct from cssp_ctrl.
module cssp_dp #(
  parameter int FRAC_BITS = cssp_pkg::FRAC_BITS_DEF,
  parameter int OUT_WIDTH = cssp_pkg::OUT_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  cssp_pkg::ctrl_t                ctrl_i,
  input  cssp_pkg::cfg_t                 cfg_i,
  input  logic                           load_i,
  input  logic [cssp_pkg::IN_W-1:0]      in0_i,
  input  logic [cssp_pkg::IN_W-1:0]      in1_i,
  output logic [cssp_pkg::RES_W-1:0]     steer_res_o,
  output logic [cssp_pkg::RES_W-1:0]     left_res_o,
  output logic [cssp_pkg::RES_W-1:0]     right_res_o
);

  localparam int IN_W    = cssp_pkg::IN_W;
  localparam int GAIN_W  = cssp_pkg::GAIN_W;
  localparam int ERR_W   = cssp_pkg::ERR_W;
  localparam int RES_W   = cssp_pkg::RES_W;
  localparam int MUL_B_W = cssp_pkg::MUL_B_W;
  localparam int PROD_W  = cssp_pkg::PROD_W;
  localparam int WW      = cssp_pkg::wide_w(FRAC_BITS, OUT_WIDTH);
  localparam int UP = (FRAC_BITS > cssp_pkg::GAIN_FRAC) ? (FRAC_BITS - cssp_pkg::GAIN_FRAC) : 0;
  localparam int DN = (FRAC_BITS < cssp_pkg::GAIN_FRAC) ? (cssp_pkg::GAIN_FRAC - FRAC_BITS) : 0;

  localparam logic signed [WW-1:0] OUT_MAX = {{(WW-OUT_WIDTH+1){1'b0}}, {(OUT_WIDTH-1){1'b1}}};
  localparam logic signed [WW-1:0] OUT_MIN = ~OUT_MAX;
  localparam logic signed [WW-1:0] RES_MAX = {{(WW-RES_W+1){1'b0}}, {(RES_W-1){1'b1}}};
  localparam logic signed [WW-1:0] RES_MIN = ~RES_MAX;

  function automatic logic [RES_W-1:0] sat_res(input logic signed [WW-1:0] v);
    logic signed [WW-1:0] r;
    r = v;
    if (v > RES_MAX) r = RES_MAX;
    else if (v < RES_MIN) r = RES_MIN;
    return r[RES_W-1:0];
  endfunction

  logic signed [IN_W-1:0]      in0_q, in1_q, prev_e_q;
  logic signed [ERR_W-1:0]     prev_l_q, prev_r_q, err_q, prev_sel;
  logic signed [OUT_WIDTH-1:0] steer_v_q, left_v_q, right_v_q, val_sel;
  logic signed [GAIN_W-1:0]    mul_a;
  logic signed [MUL_B_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]    prod_d, prod_q;
  logic signed [WW-1:0]        acc_d, acc_q, x_d, x_q;
  logic signed [WW-1:0]        val_w, st_w, base_w, speed_w, resc_w, fin_w, fin_sat;
  logic [cssp_pkg::ALPHA_W-1:0] alpha_c;

  assign alpha_c = (cfg_i.filter_alpha > cssp_pkg::ALPHA_ONE) ? cssp_pkg::ALPHA_ONE
                                                              : cfg_i.filter_alpha;

  assign prev_sel = ctrl_i.side ? prev_r_q : prev_l_q;
  assign val_sel  = ctrl_i.steer ? steer_v_q : (ctrl_i.side ? right_v_q : left_v_q);
  assign val_w    = WW'(val_sel);
  assign st_w     = WW'(steer_v_q) >>> FRAC_BITS;
  assign base_w   = WW'($signed(cfg_i.cruise_speed));
  assign speed_w  = WW'(ctrl_i.side ? in1_q : in0_q);
  assign resc_w   = (acc_q <<< UP) >>> DN;
  assign fin_w    = val_w + (acc_q >>> cssp_pkg::ALPHA_SHIFT);
  assign fin_sat  = (fin_w > OUT_MAX) ? OUT_MAX : ((fin_w < OUT_MIN) ? OUT_MIN : fin_w);

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl_i.op)
      cssp_pkg::OP_MUL0: begin
        if (ctrl_i.steer) begin
          mul_a = $signed(cfg_i.steer_kp);
          mul_b = MUL_B_W'(in0_q);
        end else begin
          mul_a = $signed(cfg_i.speed_ki);
          mul_b = MUL_B_W'(err_q);
        end
      end
      cssp_pkg::OP_MUL1: begin
        if (ctrl_i.steer) begin
          mul_a = $signed(cfg_i.steer_kd);
          mul_b = MUL_B_W'(in0_q) - MUL_B_W'(prev_e_q);
        end else begin
          mul_a = $signed(cfg_i.speed_kp);
          mul_b = MUL_B_W'(err_q) - MUL_B_W'(prev_sel);
        end
      end
      cssp_pkg::OP_MUL2: begin
        mul_a = $signed(cfg_i.gyro_gain);
        mul_b = MUL_B_W'(in1_q);
      end
      default: ;
    endcase
  end

  assign prod_d = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Accumulator and alpha multiplicand. The alpha product is built by shift and add,
  // one bit of alpha per cycle, so the wide value never meets a multiplier.
  always_comb begin
    acc_d = acc_q;
    x_d   = x_q;
    case (ctrl_i.op)
      cssp_pkg::OP_MUL0: acc_d = '0;
      cssp_pkg::OP_MUL1, cssp_pkg::OP_MUL2, cssp_pkg::OP_ACC: acc_d = acc_q + WW'(prod_q);
      cssp_pkg::OP_ERR1: acc_d = ctrl_i.side ? (base_w + st_w) : (base_w - st_w);
      cssp_pkg::OP_DIFF: begin
        x_d   = ctrl_i.steer ? (resc_w - val_w) : resc_w;
        acc_d = '0;
      end
      cssp_pkg::OP_ALPHA: begin
        if (alpha_c[ctrl_i.bit_idx]) acc_d = acc_q + x_q;
        x_d = x_q <<< 1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      in0_q <= in0_i;
      in1_q <= in1_i;
    end
    if (ctrl_i.op == cssp_pkg::OP_ERR2) err_q <= sat_res(acc_q - speed_w);
    prod_q <= prod_d;
    acc_q  <= acc_d;
    x_q    <= x_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_e_q  <= '0;
      prev_l_q  <= '0;
      prev_r_q  <= '0;
      steer_v_q <= '0;
      left_v_q  <= '0;
      right_v_q <= '0;
    end else if (ctrl_i.op == cssp_pkg::OP_FIN) begin
      if (ctrl_i.steer) begin
        steer_v_q <= fin_sat[OUT_WIDTH-1:0];
        prev_e_q  <= in0_q;
      end else if (ctrl_i.side) begin
        right_v_q <= fin_sat[OUT_WIDTH-1:0];
        prev_r_q  <= err_q;
      end else begin
        left_v_q  <= fin_sat[OUT_WIDTH-1:0];
        prev_l_q  <= err_q;
      end
    end
  end

  assign steer_res_o = sat_res(WW'(steer_v_q) >>> FRAC_BITS);
  assign left_res_o  = sat_res(WW'(left_v_q) >>> FRAC_BITS);
  assign right_res_o = sat_res(WW'(right_v_q) >>> FRAC_BITS);

endmodule

// ===== sv/cascaded_steer_speed_pid_top.sv =====
// Cascaded steer PD and wheel speed PI controller, top level; uses cssp_pkg, cssp_ctrl, cssp_dp.
// Items are handled one at a time; a new item is taken only once the sequencer is idle again.
// The pace is set by the single multiply-accumulate unit and its nine-step alpha shift-add, run
// once per loop: a steer item runs one loop, a speed item runs two, left wheel then right wheel.
// Reset (rst_ni low, asynchronous) clears the sequencer, all loop state and the output valid,
// and returns every configuration register to its default; no clearing pass follows.
`include "cascaded_steer_speed_pid_top_macros.svh"

module cascaded_steer_speed_pid_top #(
  parameter int FRAC_BITS = cssp_pkg::FRAC_BITS_DEF,
  parameter int OUT_WIDTH = cssp_pkg::OUT_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Input items.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata, low to high: track_error[15:0], gyro_rate[31:16], left_speed[47:32],
  // right_speed[63:48].
  input  logic [cssp_pkg::TDATA_IN_W-1:0]     s_axis_tdata,
  // tuser: opcode (0 steer update, 1 wheel speed update).
  input  logic                                s_axis_tuser,
  // Result items.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata, low to high: steer_out[23:0], left_drive[47:24], right_drive[71:48].
  output logic [cssp_pkg::TDATA_OUT_W-1:0]    m_axis_tdata,
  // Configuration write channel.
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [cssp_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [cssp_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int IN_W  = cssp_pkg::IN_W;
  localparam int RES_W = cssp_pkg::RES_W;

  cssp_pkg::cfg_t  cfg_q;
  cssp_pkg::ctrl_t ctrl;
  logic            s_accept;
  logic            idle;
  logic            out_free;
  logic            out_load;
  logic            m_valid_q;
  logic [cssp_pkg::TDATA_OUT_W-1:0] m_data_q;
  logic [IN_W-1:0]  in0_w, in1_w;
  logic [RES_W-1:0] steer_res, left_res, right_res;

  // Configuration registers. Writes are always taken; an index past the list is dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cruise_speed <= cssp_pkg::RST_CRUISE_SPEED;
      cfg_q.steer_kp     <= cssp_pkg::RST_STEER_KP;
      cfg_q.steer_kd     <= cssp_pkg::RST_STEER_KD;
      cfg_q.gyro_gain    <= cssp_pkg::RST_GYRO_GAIN;
      cfg_q.speed_ki     <= cssp_pkg::RST_SPEED_KI;
      cfg_q.speed_kp     <= cssp_pkg::RST_SPEED_KP;
      cfg_q.filter_alpha <= cssp_pkg::RST_FILTER_ALPHA;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        cssp_pkg::REG_CRUISE_SPEED: cfg_q.cruise_speed <= cfg_data_i;
        cssp_pkg::REG_STEER_KP:     cfg_q.steer_kp   <= cfg_data_i;
        cssp_pkg::REG_STEER_KD:     cfg_q.steer_kd   <= cfg_data_i;
        cssp_pkg::REG_GYRO_GAIN:    cfg_q.gyro_gain  <= cfg_data_i;
        cssp_pkg::REG_SPEED_KI:     cfg_q.speed_ki   <= cfg_data_i;
        cssp_pkg::REG_SPEED_KP:     cfg_q.speed_kp   <= cfg_data_i;
        cssp_pkg::REG_FILTER_ALPHA: cfg_q.filter_alpha <= cfg_data_i[cssp_pkg::ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  // An item is taken only while the sequencer is idle. The two operand slots hold the
  // error and gyro rate for a steer item, or the left and right speeds for a speed item.
  assign s_axis_tready = idle;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign in0_w = (s_axis_tuser == cssp_pkg::OPC_STEER) ? s_axis_tdata[IN_W-1:0]
                                                       : s_axis_tdata[3*IN_W-1:2*IN_W];
  assign in1_w = (s_axis_tuser == cssp_pkg::OPC_STEER) ? s_axis_tdata[2*IN_W-1:IN_W]
                                                       : s_axis_tdata[4*IN_W-1:3*IN_W];

  // The output register frees the input side: a new item may start while a result waits.
  // The sequencer only holds in its final step if that result has still not been taken.
  assign out_free = !m_valid_q || m_axis_tready;

  cssp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (s_accept),
    .opcode_i   (s_axis_tuser),
    .out_free_i (out_free),
    .ctrl_o     (ctrl),
    .idle_o     (idle),
    .out_load_o (out_load)
  );

  cssp_dp #(
    .FRAC_BITS (FRAC_BITS),
    .OUT_WIDTH (OUT_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .cfg_i       (cfg_q),
    .load_i      (s_accept),
    .in0_i       (in0_w),
    .in1_i       (in1_w),
    .steer_res_o (steer_res),
    .left_res_o  (left_res),
    .right_res_o (right_res)
  );

  // Every item reports all three held outputs, whichever loop it updated.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) m_data_q <= {right_res, left_res, steer_res};
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  `CSSP_ASSERT(a_busy_after_accept, s_accept |=> !s_axis_tready, "ready after taking an item")
  `CSSP_ASSERT_NEVER(a_no_overwrite, out_load && m_valid_q && !m_axis_tready, "result overwritten")
  `CSSP_ASSERT(a_idle_after_load, out_load |=> s_axis_tready, "not idle after a result")

endmodule
